/* rtl/cwcb_pkg.sv */
// Shared types, constants and CRC-32C helper functions for the chunk boundary finder.
package cwcb_pkg;

    // Fixed widths of the transaction fields
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned OFF_W  = 48;

    // Defaults for the top-level parameters
    localparam int unsigned WINDOW_BYTES_DEF = 32;
    localparam int unsigned OFFSET_BITS_DEF  = 48;

    // CRC-32C, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } cwcb_in_t;

    typedef struct packed {
        logic [OFF_W-1:0] boundary_offset;
        logic             end_marker;
        logic             last_result;
    } cwcb_out_t;

    // Load strobe from the input side into the result stage
    typedef struct packed {
        logic load;
        logic last;
    } cwcb_load_t;

    // One byte through the CRC register: xor the byte in, then eight shifts
    function automatic logic [CRC_W-1:0] crc_step8(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Push nbytes zero bytes through the register (elaboration only)
    function automatic logic [CRC_W-1:0] crc_zero_bytes(
        input logic [CRC_W-1:0] crc,
        input int unsigned      nbytes
    );
        logic [CRC_W-1:0] c;
        c = crc;
        for (int unsigned n = 0; n < nbytes; n++) begin
            c = crc_step8(c, '0);
        end
        return c;
    endfunction

    // Register contents for a window of all zero bytes
    function automatic logic [CRC_W-1:0] crc_zero_window(input int unsigned wbytes);
        return crc_zero_bytes(CRC_INIT, wbytes);
    endfunction

    // Constant term of the rolling update (init seen over wbytes and wbytes+1)
    function automatic logic [CRC_W-1:0] crc_roll_const(input int unsigned wbytes);
        return crc_zero_bytes(CRC_INIT, wbytes + 1) ^ crc_zero_bytes(CRC_INIT, wbytes);
    endfunction

    // Contribution of each bit of the dropped byte after wbytes+1 byte times
    function automatic logic [BYTE_W-1:0][CRC_W-1:0] crc_drop_basis(
        input int unsigned wbytes
    );
        logic [BYTE_W-1:0][CRC_W-1:0] basis;
        for (int j = 0; j < BYTE_W; j++) begin
            basis[j] = crc_zero_bytes(CRC_W'(1) << j, wbytes + 1);
        end
        return basis;
    endfunction

endpackage

/* rtl/cwcb_window.sv */
// Byte window shift line, rolling CRC-32C register and saturating byte counter.
module cwcb_window #(
    parameter int unsigned WINDOW_BYTES = cwcb_pkg::WINDOW_BYTES_DEF,
    parameter int unsigned OFFSET_BITS  = cwcb_pkg::OFFSET_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [cwcb_pkg::BYTE_W-1:0]  data_byte,
    output logic [cwcb_pkg::CRC_W-1:0]   window_crc,
    output logic [OFFSET_BITS-1:0]       bytes_seen
);
    import cwcb_pkg::*;

    localparam logic [CRC_W-1:0] RESET_CRC  = crc_zero_window(WINDOW_BYTES);
    localparam logic [CRC_W-1:0] ROLL_CONST = crc_roll_const(WINDOW_BYTES);
    localparam logic [BYTE_W-1:0][CRC_W-1:0] DROP_BASIS = crc_drop_basis(WINDOW_BYTES);

    logic [BYTE_W-1:0]      win_reg [WINDOW_BYTES];
    logic [CRC_W-1:0]       crc_reg;
    logic [CRC_W-1:0]       crc_next;
    logic [CRC_W-1:0]       drop_term;
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;

    // Dropped oldest byte, mapped through the precomputed linear basis
    always_comb
    begin
        drop_term = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (win_reg[0][j])
            begin
                drop_term = drop_term ^ DROP_BASIS[j];
            end
        end
    end

    // Rolling update: shift in the new byte, cancel the oldest one
    assign crc_next = crc_step8(crc_reg, data_byte) ^ drop_term ^ ROLL_CONST;

    // Saturating byte count
    assign cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    // Window shift line, oldest byte at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_BYTES; i++) begin
                win_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW_BYTES-1] <= data_byte;
        end
    end

    // CRC register and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= RESET_CRC;
            cnt_reg <= '0;
        end
        else if (load)
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign window_crc = crc_reg ^ CRC_INIT;
    assign bytes_seen = cnt_reg;

endmodule

/* rtl/cwcb_emit.sv */
// Result stage: threshold compare, split/end sequencing and output register.
module cwcb_emit #(
    parameter int unsigned WINDOW_BYTES = cwcb_pkg::WINDOW_BYTES_DEF,
    parameter int unsigned OFFSET_BITS  = cwcb_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cwcb_pkg::cwcb_load_t        ld,
    input  logic [cwcb_pkg::CRC_W-1:0]  window_crc,
    input  logic [OFFSET_BITS-1:0]      bytes_seen,
    input  logic                        thr_we,
    input  logic [cwcb_pkg::CRC_W-1:0]  thr_data,
    output logic                        busy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cwcb_pkg::cwcb_out_t         out_data
);
    import cwcb_pkg::*;

    localparam logic [OFFSET_BITS-1:0] WIN_CNT = OFFSET_BITS'(WINDOW_BYTES);

    logic [CRC_W-1:0]             thr_reg;
    logic                         pend_valid_reg;
    logic                         pend_last_reg;
    logic                         split_done_reg;
    logic                         out_valid_reg;
    cwcb_out_t                    out_reg;

    logic                         split_hit;
    logic                         need_split;
    logic                         out_free;
    logic                         emit_split;
    logic                         emit_end;
    logic                         drain;
    logic [OFFSET_BITS-1:0]       start_off;
    logic [OFFSET_BITS+OFF_W-1:0] start_ext;
    logic [OFFSET_BITS+OFF_W-1:0] size_ext;

    // Window test for the pending byte
    assign split_hit  = (bytes_seen > WIN_CNT) && (window_crc <= thr_reg);
    assign need_split = pend_valid_reg && split_hit && !split_done_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_split = need_split && out_free;
    assign emit_end   = !need_split && pend_valid_reg && pend_last_reg && out_free;

    // Pending byte retires once all its results are in the output register
    assign drain = pend_valid_reg &&
                   ((emit_split && !pend_last_reg) || emit_end ||
                    (!need_split && !pend_last_reg));
    assign busy  = pend_valid_reg && !drain;

    // Offsets into the 48-bit field: keep low bits, zero-extend if narrower
    assign start_off = bytes_seen - WIN_CNT;
    assign start_ext = {{OFF_W{1'b0}}, start_off};
    assign size_ext  = {{OFF_W{1'b0}}, bytes_seen};

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (thr_we)
        begin
            thr_reg <= thr_data;
        end
    end

    // Pending byte bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            split_done_reg <= 1'b0;
        end
        else if (ld.load)
        begin
            pend_valid_reg <= 1'b1;
            pend_last_reg  <= ld.last;
            split_done_reg <= 1'b0;
        end
        else if (drain)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (emit_split)
        begin
            split_done_reg <= 1'b1;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_split || emit_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit_split)
        begin
            out_reg.boundary_offset <= start_ext[OFF_W-1:0];
            out_reg.end_marker      <= 1'b0;
            out_reg.last_result     <= !pend_last_reg;
        end
        else if (emit_end)
        begin
            out_reg.boundary_offset <= size_ext[OFF_W-1:0];
            out_reg.end_marker      <= 1'b1;
            out_reg.last_result     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/crc_window_chunk_boundary.sv */
// Top level of the CRC-32C windowed content-defined chunk boundary finder.
//
// Input channel (in_valid / in_stall / in_data): one file byte per transaction,
// with last_byte marking the final byte of a file. One byte can be taken in
// every cycle while in_stall is low. The window CRC is rolled forward by a fixed
// XOR network, so the state update for a byte is done in the cycle it is accepted.
// Output channel (out_valid / out_stall / out_data): split offsets and the
// end-of-file size. A byte gives zero, one or two transactions; a split comes
// before the end marker, and last_result flags the final one of the byte.
// The window state is updated at the edge that accepts a byte; the result stage
// then loads its results into the output register once that register is free.
// Throughput: one byte per cycle while the receiver does not stall and each byte
// yields at most one result; a byte with both a split and an end marker holds
// the result stage until both results are in the output register.
// When the receiver stalls, the output register holds its transaction, and
// in_stall rises once the pending byte cannot move its results out.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes the 32-bit CRC
// threshold; cfg_ready is always high. Write it only while the block is idle.
// Reset clears the window to zero bytes, the count and threshold to zero;
// a new file starts after reset.
module crc_window_chunk_boundary #(
    parameter int unsigned WINDOW_BYTES = cwcb_pkg::WINDOW_BYTES_DEF,
    parameter int unsigned OFFSET_BITS  = cwcb_pkg::OFFSET_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cwcb_pkg::cwcb_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cwcb_pkg::cwcb_out_t         out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cwcb_pkg::CRC_W-1:0]  cfg_data
);
    import cwcb_pkg::*;

    logic                   in_acc;
    logic                   busy;
    logic [CRC_W-1:0]       window_crc;
    logic [OFFSET_BITS-1:0] bytes_seen;
    cwcb_load_t             ld;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_acc    = in_valid && !busy;
    assign ld.load   = in_acc;
    assign ld.last   = in_data.last_byte;

    cwcb_window #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_acc),
        .data_byte  (in_data.data_byte),
        .window_crc (window_crc),
        .bytes_seen (bytes_seen)
    );

    cwcb_emit #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .window_crc (window_crc),
        .bytes_seen (bytes_seen),
        .thr_we     (cfg_valid && cfg_ready),
        .thr_data   (cfg_data),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // Each accepted byte advances the count by one unless saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && in_acc) |=>
            (bytes_seen == $past(bytes_seen) + 1'b1) ||
            (($past(bytes_seen) == '1) && (bytes_seen == '1)))
        else $error("byte count did not advance on accepted byte");

    // Without an accepted byte the window state holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && !in_acc) |=> ($stable(bytes_seen) && $stable(window_crc)))
        else $error("window state changed without an accepted byte");

    // An end marker is always the final result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.end_marker) |-> out_data.last_result)
        else $error("end marker without last_result");

endmodule

/* bench/chunk_boundary_checker.sv */
// Scoreboard for the chunk boundary finder: watches all channels, predicts and compares results.
`timescale 1ns / 100ps
module chunk_boundary_checker
    import cwcb_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  cwcb_in_t         in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  cwcb_out_t        out_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CRC_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output logic [CRC_W-1:0] window_crc_now
);

    localparam logic [OFFSET_BITS-1:0] COUNT_SAT = '1;

    // Shadow copy of the block state
    logic [BYTE_W-1:0]      window_q [WINDOW_BYTES];
    logic [CRC_W-1:0]       threshold_q;
    logic [OFFSET_BITS-1:0] byte_count;

    // Results still owed by the block, oldest first
    cwcb_out_t expected_chunks [$];
    cwcb_out_t oldest;
    int        mismatches = 0;

    assign fail_count = mismatches;

    // Slide one byte into the window and queue the splits / end marker it causes
    task automatic predict_boundaries(input cwcb_in_t item);
        logic [CRC_W-1:0]       crc;
        logic [OFFSET_BITS-1:0] start;
        cwcb_out_t              res;
        bit                     split;

        for (int i = 0; i < WINDOW_BYTES - 1; i++)
        begin
            window_q[i] = window_q[i + 1];
        end
        window_q[WINDOW_BYTES - 1] = item.data_byte;

        // CRC-32C over the whole window, oldest byte first
        crc = CRC_INIT;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            crc = crc ^ CRC_W'(window_q[i]);
            for (int b = 0; b < BYTE_W; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        crc = ~crc;
        window_crc_now <= crc;

        // count saturates instead of wrapping
        if (byte_count != COUNT_SAT)
        begin
            byte_count = byte_count + 1'b1;
        end

        // only windows starting at offset 1 or later are tested
        split = (byte_count > WINDOW_BYTES) && (crc <= threshold_q);
        start = byte_count - WINDOW_BYTES;

        if (split)
        begin
            res.boundary_offset = OFF_W'(start);
            res.end_marker      = 1'b0;
            res.last_result     = !item.last_byte;
            expected_chunks.push_back(res);
        end
        if (item.last_byte)
        begin
            res.boundary_offset = OFF_W'(byte_count);
            res.end_marker      = 1'b1;
            res.last_result     = 1'b1;
            expected_chunks.push_back(res);
        end
    endtask

    // Sample every channel at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_BYTES; i++)
            begin
                window_q[i] = '0;
            end
            threshold_q = '0;
            byte_count  = '0;
            expected_chunks.delete();
            window_crc_now <= '0;
            pending        <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_q = cfg_data;
            end

            // compare a finished output transaction with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_chunks.size() == 0)
                begin
                    $error("unexpected result: boundary_offset %0d end_marker %0b last_result %0b",
                           out_data.boundary_offset, out_data.end_marker,
                           out_data.last_result);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_chunks.pop_front();
                    if (out_data.boundary_offset !== oldest.boundary_offset)
                    begin
                        $error("boundary_offset: expected %0d, actual %0d",
                               oldest.boundary_offset, out_data.boundary_offset);
                        mismatches++;
                    end
                    if (out_data.end_marker !== oldest.end_marker)
                    begin
                        $error("end_marker: expected %0b, actual %0b",
                               oldest.end_marker, out_data.end_marker);
                        mismatches++;
                    end
                    if (out_data.last_result !== oldest.last_result)
                    begin
                        $error("last_result: expected %0b, actual %0b",
                               oldest.last_result, out_data.last_result);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                predict_boundaries(in_data);
            end

            pending <= expected_chunks.size();
        end
    end

endmodule

/* bench/tb_crc_window_chunk_boundary.sv */
// Testbench top for the chunk boundary finder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_crc_window_chunk_boundary;
    import cwcb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 500;
    localparam int RETUNE_ITEMS  = 120;

    localparam logic [CRC_W-1:0] THRESH_MIN = '0;
    localparam logic [CRC_W-1:0] THRESH_MAX = '1;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    cwcb_in_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    cwcb_out_t        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CRC_W-1:0] cfg_data  = '0;

    int               fail_count;
    int               pending;
    logic [CRC_W-1:0] window_crc_now;

    int cycle_count    = 0;
    int send_idle_pct  = 10;
    int recv_stall_pct = 63;
    int bytes_sent     = 0;

    always #1 clk = ~clk;

    crc_window_chunk_boundary u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    chunk_boundary_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .window_crc_now (window_crc_now)
    );

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One byte transaction, then a random idle stretch on the sender side
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
    endtask

    // Hold off the sender until every expected result is out, plus the pipe depth
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [CRC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // A file with random length and content style; last_byte on its final byte
    task automatic send_file();
        int                len;
        int                style;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] b;

        case ($urandom_range(9, 0))
            0:       len = $urandom_range(3, 1);
            1, 2:    len = $urandom_range(200, 61);
            default: len = $urandom_range(60, 1);
        endcase
        style = $urandom_range(9, 0);
        fill  = BYTE_W'($urandom_range(255, 0));
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0:       b = 8'h00;
                1:       b = fill;
                2:       b = 8'hFF;
                default: b = BYTE_W'($urandom_range(255, 0));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // Random files, retuning the threshold every so often while idle
    task automatic run_random(input int items);
        int               target;
        int               next_retune;
        logic [CRC_W-1:0] thr;

        target      = bytes_sent + items;
        next_retune = bytes_sent + RETUNE_ITEMS;
        while (bytes_sent < target)
        begin
            send_file();
            if (bytes_sent >= next_retune)
            begin
                wait_idle();
                case ($urandom_range(5, 0))
                    0:       thr = THRESH_MIN;
                    1:       thr = THRESH_MAX;
                    2:       thr = $urandom;
                    3:       thr = $urandom >> 2;
                    4:       thr = $urandom >> 6;
                    default: thr = $urandom >> 4;
                endcase
                write_threshold(thr);
                next_retune += RETUNE_ITEMS;
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [CRC_W-1:0] zero_crc;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short file: no window tested, only the end marker
        for (int i = 0; i < 5; i++)
        begin
            send_byte(8'h00, i == 4);
        end
        // stream goes on past the last byte; windows now tested against threshold 0
        for (int i = 0; i < 29; i++)
        begin
            send_byte(8'h00, 1'b0);
        end
        wait_idle();

        // threshold equal to the all-zero window CRC: every window splits
        zero_crc = window_crc_now;
        write_threshold(zero_crc);
        for (int i = 0; i < 3; i++)
        begin
            send_byte(8'h00, i == 2);
        end
        wait_idle();

        // one below: nothing splits
        write_threshold(zero_crc - 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();

        // top threshold: split on every byte, split then end marker on last bytes
        write_threshold(THRESH_MAX);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h55, 1'b1);
        wait_idle();
        write_threshold($urandom >> 4);

        // random files under three idle profiles
        run_random(PHASE_ITEMS);
        wait_idle();
        send_idle_pct  = 63;
        recv_stall_pct = 10;
        run_random(PHASE_ITEMS);
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        wait_idle();

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/cwcb_pkg.sv
rtl/cwcb_window.sv
rtl/cwcb_emit.sv
rtl/crc_window_chunk_boundary.sv
bench/chunk_boundary_checker.sv
bench/tb_crc_window_chunk_boundary.sv
